/* design/i2cbb_pkg.sv */
// Shared constants, codes and payload types of the I2C register-transaction sequencer.
package i2cbb_pkg;

  localparam int unsigned MaxWriteBytes = 16;
  localparam int unsigned BufAw = (MaxWriteBytes > 1) ? $clog2(MaxWriteBytes) : 1;
  localparam int unsigned LdPtrW = $clog2(MaxWriteBytes + 1);

  localparam logic [1:0] ReqTick    = 2'd0;
  localparam logic [1:0] ReqStartWr = 2'd1;
  localparam logic [1:0] ReqStartRd = 2'd2;
  localparam logic [1:0] ReqLoad    = 2'd3;

  localparam logic [2:0] ErrOk       = 3'd0;
  localparam logic [2:0] ErrStart    = 3'd1;
  localparam logic [2:0] ErrAddrNack = 3'd2;
  localparam logic [2:0] ErrDataNack = 3'd3;
  localparam logic [2:0] ErrTooLong  = 3'd4;

  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [4:0] {
    PhIdle, PhSt1, PhSt2, PhTxl, PhTxd, PhTxh, PhAckl, PhAckd, PhAckh, PhAcks,
    PhRxl, PhRxh, PhRxs, PhMad, PhMah, PhMal, PhP0, PhP1, PhP2, PhP3
  } phase_e;

  typedef enum logic [1:0] {
    SgAddrW, SgReg, SgDataW, SgAddrR
  } stage_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       busy_res;
    logic       done_res;
    logic [2:0] error_code;
  } rsp_t;

  typedef struct packed {
    logic             en;
    logic [BufAw-1:0] addr;
    logic [7:0]       data;
  } wbuf_wr_t;

endpackage

/* design/i2cbb_intf.sv */
// Handshake channel interfaces for requests, results and the configuration register.
interface i2cbb_req_if;
  import i2cbb_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cbb_rsp_if;
  import i2cbb_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cbb_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/i2cbb_wbuf.sv */
// Generic RAM with one write port and one registered read port.
module i2cbb_wbuf #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/i2cbb_step.sv */
// Bus sequencing state and the single-step transition logic for one request.
module i2cbb_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  i2cbb_pkg::req_t             req_i,
  input  logic                        nack_ignore_i,
  input  logic [7:0]                  buf_rd_data_i,
  output logic [i2cbb_pkg::BufAw-1:0] buf_rd_idx_o,
  output i2cbb_pkg::wbuf_wr_t         buf_wr_o,
  output i2cbb_pkg::rsp_t             rsp_o
);
  import i2cbb_pkg::*;

  typedef struct packed {
    phase_e            phase;
    stage_e            stage;
    logic [2:0]        err_pend;
    logic [3:0]        bit_cnt;
    logic [7:0]        shift;
    logic [7:0]        byte_cnt;
    logic [LdPtrW-1:0] ld_ptr;
    logic [7:0]        dev;
    logic [7:0]        regb;
    logic [7:0]        len;
    logic              read_mode;
    logic              scl;
    logic              sda;
  } st_t;

  localparam st_t StReset = '{
    phase: PhIdle, stage: SgAddrW, err_pend: ErrOk, bit_cnt: '0, shift: '0,
    byte_cnt: '0, ld_ptr: '0, dev: '0, regb: '0, len: '0, read_mode: 1'b0,
    scl: 1'b1, sda: 1'b1
  };
  localparam logic [8:0]        LenLimit = 9'(MaxWriteBytes);
  localparam logic [LdPtrW-1:0] LdLimit  = LdPtrW'(MaxWriteBytes);

  st_t        s_q, s_d;
  logic       done;
  logic [2:0] err;
  logic       rxv;
  logic [7:0] rxb;
  logic [3:0] bc_inc;
  logic [7:0] byc_inc;
  logic [7:0] rx_shift;

  function automatic st_t send_begin(st_t s, logic [7:0] b);
    s.shift   = b;
    s.bit_cnt = '0;
    s.scl     = 1'b0;
    s.phase   = PhTxd;
    return s;
  endfunction

  function automatic st_t stop_begin(st_t s, logic [2:0] code);
    s.err_pend = code;
    s.scl      = 1'b0;
    s.phase    = PhP1;
    return s;
  endfunction

  assign bc_inc       = s_q.bit_cnt + 4'd1;
  assign byc_inc      = s_q.byte_cnt + 8'd1;
  assign rx_shift     = {s_q.shift[6:0], req_i.sda_in};
  assign buf_rd_idx_o = (s_q.stage == SgReg) ? '0 : BufAw'(byc_inc);

  always_comb begin
    s_d      = s_q;
    done     = 1'b0;
    err      = ErrOk;
    rxv      = 1'b0;
    rxb      = '0;
    buf_wr_o = '0;
    if (step_i) begin
      if (s_q.phase == PhIdle) begin
        if (req_i.req_type == ReqStartWr || req_i.req_type == ReqStartRd) begin
          s_d.dev       = req_i.dev_addr;
          s_d.regb      = req_i.reg_addr;
          s_d.len       = req_i.length;
          s_d.read_mode = (req_i.req_type == ReqStartRd);
          if (!s_d.read_mode && ({1'b0, req_i.length} > LenLimit)) begin
            done       = 1'b1;
            err        = ErrTooLong;
            s_d.ld_ptr = '0;
          end else begin
            s_d.stage    = SgAddrW;
            s_d.err_pend = ErrOk;
            s_d.byte_cnt = '0;
            s_d.scl      = 1'b1;
            s_d.sda      = 1'b1;
            s_d.phase    = PhSt1;
          end
        end else if (req_i.req_type == ReqLoad && s_q.ld_ptr < LdLimit) begin
          buf_wr_o.en   = 1'b1;
          buf_wr_o.addr = BufAw'(s_q.ld_ptr);
          buf_wr_o.data = req_i.data_byte;
          s_d.ld_ptr    = s_q.ld_ptr + 1'b1;
        end
      end else if (req_i.req_type == ReqTick) begin
        case (s_q.phase)
          PhSt1, PhSt2: begin
            if (req_i.sda_in == (s_q.phase == PhSt2)) begin
              if (s_q.stage == SgAddrR) begin
                s_d = send_begin(s_d, s_q.dev | ReadBit);
              end else begin
                done      = 1'b1;
                err       = ErrStart;
                s_d.phase = PhIdle;
                if (!s_q.read_mode) begin
                  s_d.ld_ptr = '0;
                end
              end
            end else if (s_q.phase == PhSt1) begin
              s_d.sda   = 1'b0;
              s_d.phase = PhSt2;
            end else begin
              s_d.sda     = 1'b0;
              s_d.shift   = (s_q.stage == SgAddrR) ? (s_q.dev | ReadBit) : s_q.dev;
              s_d.bit_cnt = '0;
              s_d.phase   = PhTxl;
            end
          end
          PhTxl: begin
            s_d.scl   = 1'b0;
            s_d.phase = PhTxd;
          end
          PhTxd: begin
            s_d.sda   = s_q.shift[7];
            s_d.shift = {s_q.shift[6:0], 1'b0};
            s_d.phase = PhTxh;
          end
          PhTxh: begin
            s_d.scl     = 1'b1;
            s_d.bit_cnt = bc_inc;
            s_d.phase   = (bc_inc >= 4'd8) ? PhAckl : PhTxl;
          end
          PhAckl: begin
            s_d.scl   = 1'b0;
            s_d.phase = PhAckd;
          end
          PhAckd: begin
            s_d.sda   = 1'b1;
            s_d.phase = PhAckh;
          end
          PhAckh: begin
            s_d.scl   = 1'b1;
            s_d.phase = PhAcks;
          end
          PhAcks: begin
            case (s_q.stage)
              SgAddrW: begin
                if (req_i.sda_in) begin
                  s_d = stop_begin(s_d, ErrAddrNack);
                end else begin
                  s_d.stage = SgReg;
                  s_d = send_begin(s_d, s_q.regb);
                end
              end
              SgReg: begin
                if (s_q.read_mode) begin
                  s_d.stage = SgAddrR;
                  s_d.scl   = 1'b1;
                  s_d.sda   = 1'b1;
                  s_d.phase = PhSt1;
                end else if (s_q.len != '0) begin
                  s_d.stage    = SgDataW;
                  s_d.byte_cnt = '0;
                  s_d = send_begin(s_d, buf_rd_data_i);
                end else begin
                  s_d = stop_begin(s_d, ErrOk);
                end
              end
              SgDataW: begin
                if (req_i.sda_in && !nack_ignore_i) begin
                  s_d = stop_begin(s_d, ErrDataNack);
                end else begin
                  s_d.byte_cnt = byc_inc;
                  if (byc_inc < s_q.len) begin
                    s_d = send_begin(s_d, buf_rd_data_i);
                  end else begin
                    s_d = stop_begin(s_d, ErrOk);
                  end
                end
              end
              default: begin
                s_d.byte_cnt = '0;
                if (s_q.len != '0) begin
                  s_d.sda     = 1'b1;
                  s_d.scl     = 1'b0;
                  s_d.bit_cnt = '0;
                  s_d.shift   = '0;
                  s_d.phase   = PhRxh;
                end else begin
                  s_d = stop_begin(s_d, ErrOk);
                end
              end
            endcase
          end
          PhRxl: begin
            s_d.sda     = 1'b1;
            s_d.scl     = 1'b0;
            s_d.bit_cnt = '0;
            s_d.shift   = '0;
            s_d.phase   = PhRxh;
          end
          PhRxh: begin
            s_d.scl   = 1'b1;
            s_d.phase = PhRxs;
          end
          PhRxs: begin
            s_d.shift   = rx_shift;
            s_d.bit_cnt = bc_inc;
            s_d.scl     = 1'b0;
            if (bc_inc < 4'd8) begin
              s_d.phase = PhRxh;
            end else begin
              rxv          = 1'b1;
              rxb          = rx_shift;
              s_d.byte_cnt = byc_inc;
              s_d.phase    = PhMad;
            end
          end
          PhMad: begin
            s_d.sda   = (s_q.byte_cnt >= s_q.len);
            s_d.phase = PhMah;
          end
          PhMah: begin
            s_d.scl   = 1'b1;
            s_d.phase = PhMal;
          end
          PhMal: begin
            s_d.scl = 1'b0;
            if (s_q.byte_cnt < s_q.len) begin
              s_d.phase = PhRxl;
            end else begin
              s_d.err_pend = ErrOk;
              s_d.phase    = PhP0;
            end
          end
          PhP0: begin
            s_d.scl   = 1'b0;
            s_d.phase = PhP1;
          end
          PhP1: begin
            s_d.sda   = 1'b0;
            s_d.phase = PhP2;
          end
          PhP2: begin
            s_d.scl   = 1'b1;
            s_d.phase = PhP3;
          end
          PhP3: begin
            s_d.sda   = 1'b1;
            done      = 1'b1;
            err       = s_q.err_pend;
            s_d.phase = PhIdle;
            if (!s_q.read_mode) begin
              s_d.ld_ptr = '0;
            end
          end
          default: begin
            s_d.phase = PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= StReset;
    end else begin
      s_q <= s_d;
    end
  end

  assign rsp_o.scl_out    = s_d.scl;
  assign rsp_o.sda_out    = s_d.sda;
  assign rsp_o.rx_valid   = rxv;
  assign rsp_o.rx_byte    = rxb;
  assign rsp_o.busy_res   = (s_d.phase != PhIdle);
  assign rsp_o.done_res   = done;
  assign rsp_o.error_code = err;

endmodule

/* design/i2c_master_bitbang_sequencer_unit.sv */
// Top level of the I2C register-transaction sequencer: request and result registers.
//
//   channel  dir  payload                                           transfer when
//   req_i    in   req_type dev_addr reg_addr length data_byte sda_in valid && ready
//   rsp_o    out  scl_out sda_out rx_valid rx_byte busy/done error  valid && ready
//   cfg_i    in   data_nack_ignore                                  valid && ready
//
// Every request gives exactly one result, through the request register and then the result
// register; one request is taken in every cycle while the output is not stalled.
// The request register feeds one step of the sequencer, which writes the result register.
// A stalled result register holds the step, and the request side stops once both are full.
// Reset leaves the bus released and the sequencer idle; cfg_i is always ready.
module i2c_master_bitbang_sequencer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cbb_req_if.sink         req_i,
  i2cbb_rsp_if.source       rsp_o,
  i2cbb_cfg_if.sink         cfg_i
);
  import i2cbb_pkg::*;

  logic             req_vld_q;
  req_t             req_q;
  logic             rsp_vld_q;
  rsp_t             rsp_q;
  logic             nack_ign_q;
  logic             advance;
  rsp_t             step_rsp;
  wbuf_wr_t         buf_wr;
  logic [BufAw-1:0] buf_rd_idx;
  logic [7:0]       buf_rd_data;

  assign advance     = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q <= req_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= step_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nack_ign_q <= 1'b0;
    end else if (cfg_i.valid) begin
      nack_ign_q <= cfg_i.data;
    end
  end

  i2cbb_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .req_i         (req_q),
    .nack_ignore_i (nack_ign_q),
    .buf_rd_data_i (buf_rd_data),
    .buf_rd_idx_o  (buf_rd_idx),
    .buf_wr_o      (buf_wr),
    .rsp_o         (step_rsp)
  );

  i2cbb_wbuf #(
    .Width (8),
    .Depth (MaxWriteBytes)
  ) u_wbuf (
    .clk_i     (clk_i),
    .wr_en_i   (buf_wr.en),
    .wr_addr_i (buf_wr.addr),
    .wr_data_i (buf_wr.data),
    .rd_addr_i (buf_rd_idx),
    .rd_data_o (buf_rd_data)
  );

  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

`ifndef NO_ASSERTIONS
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_vld_q)
    else $error("A step did not load the result register.");

  a_err_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !rsp_q.done_res |-> rsp_q.error_code == ErrOk)
    else $error("An error code was given without a finished transaction.");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rsp_q.done_res |-> !rsp_q.busy_res)
    else $error("A finished transaction still reports busy.");

  a_rx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && rsp_q.rx_valid |-> rsp_q.busy_res && !rsp_q.done_res)
    else $error("A received byte was reported outside a read transaction.");

  a_no_step_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q && !rsp_o.ready |-> !advance)
    else $error("The sequencer stepped while the result register was stalled.");
`endif

endmodule
